>>> sv/sqga_pkg.sv
// sqga_pkg: beat types, register indexes and command codes for the
// single-qubit gate engine. No dependencies.
`default_nettype none

package sqga_pkg;

    localparam int AMP_W       = 32;
    localparam int INDEX_W     = 10;
    localparam int CMD_W       = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int TARGET_W    = 4;
    localparam int WORD_W      = 2 * AMP_W;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_APPLY = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_U00    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_U01    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_U10    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_U11    = 3'd4;

    localparam logic [WORD_W-1:0] U_ONE  = 64'h4000_0000_0000_0000;
    localparam logic [WORD_W-1:0] U_ZERO = 64'h0;

    typedef struct packed {
        logic signed [AMP_W-1:0] re;
        logic signed [AMP_W-1:0] im;
    } cplx_t;

    typedef struct packed {
        cplx_t u00;
        cplx_t u01;
        cplx_t u10;
        cplx_t u11;
    } gate_t;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [INDEX_W-1:0]      amp_index;
        logic signed [AMP_W-1:0] amp_re;
        logic signed [AMP_W-1:0] amp_im;
    } in_item_t;

    typedef struct packed {
        logic signed [AMP_W-1:0] out_re;
        logic signed [AMP_W-1:0] out_im;
        logic [INDEX_W-1:0]      out_index;
    } out_item_t;

endpackage

`default_nettype wire

>>> sv/single_qubit_gate_apply_top.sv
// single_qubit_gate_apply_top: state vector store with single-qubit gate sweep.
// Depends on sqga_pkg, sqga_ram and sqga_butterfly.
//
// Usage:
//   s_ channel: one beat per command (write, read or apply). m_ channel: one
//   result beat per command, echoing amp_index; real and imaginary parts are
//   zero except for a read. cfg_ channel: register writes (target qubit,
//   matrix entries), always ready, to be issued only while the block is idle.
//   Amplitudes live in two RAM banks split by the parity of the basis index,
//   so both members of a pair sit in different banks.
//   A write goes from idle straight to the result state; a read passes a
//   read-wait state first. An apply sweeps 2^(QUBITS-1) pairs, one pair per
//   cycle (one read and one write port per bank), then drains its pipeline;
//   an apply with a target at or above QUBITS goes straight to the result state.
//   One command is in flight at a time; the next input beat is taken while
//   the previous result still waits in the output register.
//   Reset clears control state and sets the identity gate on qubit 0; the
//   amplitude store is undefined until written.
//   If the receiver stalls, the result holds in the output register and the
//   following command waits before returning its own result.
`default_nettype none

module single_qubit_gate_apply_top #(
    parameter int QUBITS = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire sqga_pkg::in_item_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output sqga_pkg::out_item_t                      m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sqga_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sqga_pkg::WORD_W-1:0]         cfg_data
);

    localparam int BANK_AW = (QUBITS > 1) ? QUBITS - 1 : 1;
    localparam int PAIR_W  = BANK_AW;
    localparam logic [PAIR_W-1:0] PAIR_LAST = PAIR_W'((1 << (QUBITS - 1)) - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDWAIT = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    typedef struct packed {
        logic               vld;
        logic               p0;
        logic [BANK_AW-1:0] a0;
        logic [BANK_AW-1:0] a1;
    } pair_tag_t;

    logic [2:0]                      state_reg, state_next;
    logic [PAIR_W-1:0]               pair_cnt_reg, pair_cnt_next;
    pair_tag_t                       tag_issue, tag1_reg, tag2_reg, tag3_reg;
    logic                            m_valid_reg, m_valid_next;
    sqga_pkg::out_item_t             m_data_reg;
    logic [sqga_pkg::TARGET_W-1:0]   target_reg;
    sqga_pkg::gate_t                 gate_reg;
    logic                            rd_bank_reg;
    logic [sqga_pkg::INDEX_W-1:0]    pend_index_reg;
    logic [sqga_pkg::AMP_W-1:0]      pend_re_reg, pend_im_reg;

    logic                            in_fire, out_load;
    logic [QUBITS-1:0]               slot, pair_ext, low_mask, bit_mask, b0, b1;
    logic                            in_bank;
    logic [BANK_AW-1:0]              in_addr;
    logic                            we0, we1;
    logic [BANK_AW-1:0]              waddr0, waddr1, raddr0, raddr1;
    logic [sqga_pkg::WORD_W-1:0]     wdata0, wdata1, rdata0, rdata1;
    sqga_pkg::cplx_t                 c0, c1, new0, new1;
    logic                            target_ok;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;
    assign out_load  = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign target_ok = int'(target_reg) < QUBITS;

    assign slot    = QUBITS'(s_data.amp_index);
    assign in_bank = ^slot;
    assign in_addr = BANK_AW'(slot >> 1);

    // pair address: insert a zero at the target bit
    always_comb begin
        pair_ext = QUBITS'(pair_cnt_reg);
        for (int j = 0; j < QUBITS; j++) begin
            low_mask[j] = (j < int'(target_reg));
            bit_mask[j] = (j == int'(target_reg));
        end
        b0 = ((pair_ext & ~low_mask) << 1) | (pair_ext & low_mask);
        b1 = b0 | bit_mask;
        tag_issue.vld = (state_reg == ST_SWEEP);
        tag_issue.p0  = ^b0;
        tag_issue.a0  = BANK_AW'(b0 >> 1);
        tag_issue.a1  = BANK_AW'(b1 >> 1);
    end

    always_comb begin
        if (tag_issue.vld) begin
            raddr0 = tag_issue.p0 ? tag_issue.a1 : tag_issue.a0;
            raddr1 = tag_issue.p0 ? tag_issue.a0 : tag_issue.a1;
        end else begin
            raddr0 = in_addr;
            raddr1 = in_addr;
        end
        c0 = tag1_reg.p0 ? rdata1 : rdata0;
        c1 = tag1_reg.p0 ? rdata0 : rdata1;
        we0    = 1'b0;
        we1    = 1'b0;
        waddr0 = in_addr;
        waddr1 = in_addr;
        wdata0 = {s_data.amp_re, s_data.amp_im};
        wdata1 = {s_data.amp_re, s_data.amp_im};
        if (tag3_reg.vld) begin
            we0    = 1'b1;
            we1    = 1'b1;
            waddr0 = tag3_reg.p0 ? tag3_reg.a1 : tag3_reg.a0;
            waddr1 = tag3_reg.p0 ? tag3_reg.a0 : tag3_reg.a1;
            wdata0 = tag3_reg.p0 ? new1 : new0;
            wdata1 = tag3_reg.p0 ? new0 : new1;
        end else if (in_fire && s_data.command == sqga_pkg::CMD_WRITE) begin
            we0 = !in_bank;
            we1 = in_bank;
        end
    end

    sqga_ram #(
        .WIDTH  (sqga_pkg::WORD_W),
        .ADDR_W (BANK_AW)
    ) u_bank0 (
        .clk   (aclk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .raddr (raddr0),
        .rdata (rdata0)
    );

    sqga_ram #(
        .WIDTH  (sqga_pkg::WORD_W),
        .ADDR_W (BANK_AW)
    ) u_bank1 (
        .clk   (aclk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    sqga_butterfly u_butterfly (
        .clk  (aclk),
        .gate (gate_reg),
        .c0   (c0),
        .c1   (c1),
        .new0 (new0),
        .new1 (new1)
    );

    always_comb begin
        state_next    = state_reg;
        pair_cnt_next = pair_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                pair_cnt_next = '0;
                if (in_fire) begin
                    if (s_data.command == sqga_pkg::CMD_READ) begin
                        state_next = ST_RDWAIT;
                    end else if (s_data.command == sqga_pkg::CMD_APPLY && target_ok) begin
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RDWAIT: begin
                state_next = ST_RESULT;
            end
            ST_SWEEP: begin
                pair_cnt_next = pair_cnt_reg + 1'b1;
                if (pair_cnt_reg == PAIR_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!tag1_reg.vld && !tag2_reg.vld && !tag3_reg.vld) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pair_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            tag1_reg     <= '0;
            tag2_reg     <= '0;
            tag3_reg     <= '0;
            target_reg   <= '0;
            gate_reg     <= {sqga_pkg::U_ONE, sqga_pkg::U_ZERO,
                             sqga_pkg::U_ZERO, sqga_pkg::U_ONE};
        end else begin
            state_reg    <= state_next;
            pair_cnt_reg <= pair_cnt_next;
            m_valid_reg  <= m_valid_next;
            tag1_reg     <= tag_issue;
            tag2_reg     <= tag1_reg;
            tag3_reg     <= tag2_reg;
            if (cfg_valid) begin
                unique case (cfg_index)
                    sqga_pkg::CFG_TARGET: target_reg   <= cfg_data[sqga_pkg::TARGET_W-1:0];
                    sqga_pkg::CFG_U00:    gate_reg.u00 <= cfg_data;
                    sqga_pkg::CFG_U01:    gate_reg.u01 <= cfg_data;
                    sqga_pkg::CFG_U10:    gate_reg.u10 <= cfg_data;
                    sqga_pkg::CFG_U11:    gate_reg.u11 <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pend_index_reg <= s_data.amp_index;
            pend_re_reg    <= '0;
            pend_im_reg    <= '0;
            rd_bank_reg    <= in_bank;
        end
        if (state_reg == ST_RDWAIT) begin
            pend_re_reg <= rd_bank_reg ? rdata1[63:32] : rdata0[63:32];
            pend_im_reg <= rd_bank_reg ? rdata1[31:0]  : rdata0[31:0];
        end
        if (out_load) begin
            m_data_reg.out_re    <= pend_re_reg;
            m_data_reg.out_im    <= pend_im_reg;
            m_data_reg.out_index <= pend_index_reg;
        end
    end

endmodule

`default_nettype wire

>>> sv/sqga_ram.sv
// sqga_ram: generic simple dual-port RAM, one write port and one read port
// with registered read data. No dependencies.
`default_nettype none

module sqga_ram #(
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 9
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/sqga_butterfly.sv
// sqga_butterfly: complex 2x2 matrix times amplitude pair, rounded and
// saturated. Two register stages, result combinational after the second.
// Depends on sqga_pkg.
`default_nettype none

module sqga_butterfly (
    input  wire logic           clk,
    input  wire sqga_pkg::gate_t gate,
    input  wire sqga_pkg::cplx_t c0,
    input  wire sqga_pkg::cplx_t c1,
    output sqga_pkg::cplx_t      new0,
    output sqga_pkg::cplx_t      new1
);

    localparam int PROD_W = 2 * sqga_pkg::AMP_W;
    localparam int RND_W  = PROD_W - 30;
    localparam int SUM_W  = RND_W + 2;
    localparam logic signed [PROD_W-1:0] HALF = 64'sd536870912;
    localparam logic signed [SUM_W-1:0]  SAT_MAX = 36'sd2147483647;
    localparam logic signed [SUM_W-1:0]  SAT_MIN = -36'sd2147483648;

    // [row][col][term]: re*re, im*im, re*im, im*re
    logic signed [PROD_W-1:0] prod_reg [2][2][4];
    logic signed [PROD_W-1:0] prod_next [2][2][4];
    logic signed [RND_W-1:0]  rnd_reg [2][2][4];
    logic signed [RND_W-1:0]  rnd_next [2][2][4];
    sqga_pkg::cplx_t          m [2][2];
    sqga_pkg::cplx_t          cv [2];
    sqga_pkg::cplx_t          res [2];

    always_comb begin
        logic signed [PROD_W-1:0] s;
        logic signed [SUM_W-1:0]  sre;
        logic signed [SUM_W-1:0]  sim;
        m[0][0] = gate.u00;
        m[0][1] = gate.u01;
        m[1][0] = gate.u10;
        m[1][1] = gate.u11;
        cv[0]   = c0;
        cv[1]   = c1;
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
                prod_next[r][c][0] = m[r][c].re * cv[c].re;
                prod_next[r][c][1] = m[r][c].im * cv[c].im;
                prod_next[r][c][2] = m[r][c].re * cv[c].im;
                prod_next[r][c][3] = m[r][c].im * cv[c].re;
                for (int t = 0; t < 4; t++) begin
                    s = prod_reg[r][c][t] + HALF;
                    rnd_next[r][c][t] = s[PROD_W-1:30];
                end
            end
        end
        for (int r = 0; r < 2; r++) begin
            sre = SUM_W'(rnd_reg[r][0][0]) - SUM_W'(rnd_reg[r][0][1])
                + SUM_W'(rnd_reg[r][1][0]) - SUM_W'(rnd_reg[r][1][1]);
            sim = SUM_W'(rnd_reg[r][0][2]) + SUM_W'(rnd_reg[r][0][3])
                + SUM_W'(rnd_reg[r][1][2]) + SUM_W'(rnd_reg[r][1][3]);
            if (sre > SAT_MAX) begin
                res[r].re = SAT_MAX[31:0];
            end else if (sre < SAT_MIN) begin
                res[r].re = SAT_MIN[31:0];
            end else begin
                res[r].re = sre[31:0];
            end
            if (sim > SAT_MAX) begin
                res[r].im = SAT_MAX[31:0];
            end else if (sim < SAT_MIN) begin
                res[r].im = SAT_MIN[31:0];
            end else begin
                res[r].im = sim[31:0];
            end
        end
    end

    always_ff @(posedge clk) begin
        prod_reg <= prod_next;
        rnd_reg  <= rnd_next;
    end

    assign new0 = res[0];
    assign new1 = res[1];

endmodule

`default_nettype wire

>>> verif/tb_single_qubit_gate_apply_top.sv
// tb_single_qubit_gate_apply_top: self-checking bench for the state-vector gate engine,
// a directed table then gated random phases, each result beat checked against a table entry or a predictor.
// Depends on sqga_pkg and single_qubit_gate_apply_top.
module tb_single_qubit_gate_apply_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sqga_pkg::*;

    localparam int QUBITS    = 10;
    localparam int VEC_LEN   = 1 << QUBITS;
    localparam int PHASES    = 9;
    localparam int PER_PHASE = 16;
    localparam int LONG_HOLD = 300;
    localparam longint LIMIT = 3_000_000;

    localparam logic [CMD_W-1:0]       CMD_SPARE = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_U11 + 3'd1;

    localparam logic signed [AMP_W-1:0] AMP_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [AMP_W-1:0] AMP_MIN   = 32'sh8000_0000;
    localparam logic signed [AMP_W-1:0] ONE       = 32'sh4000_0000;
    localparam logic signed [AMP_W-1:0] MINUS_ONE = 32'shC000_0000;
    localparam logic signed [AMP_W-1:0] ZERO      = 32'sh0000_0000;
    localparam logic signed [AMP_W-1:0] INV_SQRT2 = 32'sh2D41_3CCD;

    typedef enum {
        G_HADAMARD, G_PAULI_X, G_PAULI_Y, G_PAULI_Z, G_SMALL, G_FLOOR, G_CEIL, G_NOISE
    } gate_kind_e;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } probe_t;

    // untyped rows take their expectation from the predictor
    localparam probe_t PROBES [0:18] = '{
        '{'{CMD_WRITE, 10'd0,    AMP_MAX, AMP_MIN},   1'b1, '{ZERO, ZERO, 10'd0}},
        '{'{CMD_WRITE, 10'd1023, AMP_MIN, AMP_MAX},   1'b1, '{ZERO, ZERO, 10'd1023}},
        '{'{CMD_READ,  10'd0,    ZERO, ZERO},         1'b1, '{AMP_MAX, AMP_MIN, 10'd0}},
        '{'{CMD_READ,  10'd1023, ZERO, ZERO},         1'b1, '{AMP_MIN, AMP_MAX, 10'd1023}},
        '{'{CMD_SPARE, 10'd1023, ONE, ONE},           1'b1, '{ZERO, ZERO, 10'd1023}},
        '{'{CMD_READ,  10'd1023, ZERO, ZERO},         1'b1, '{AMP_MIN, AMP_MAX, 10'd1023}},
        '{'{CMD_APPLY, 10'd512,  AMP_MAX, AMP_MAX},   1'b1, '{ZERO, ZERO, 10'd512}},
        '{'{CMD_READ,  10'd0,    ZERO, ZERO},         1'b1, '{AMP_MAX, AMP_MIN, 10'd0}},
        '{'{CMD_WRITE, 10'd1,    ONE, MINUS_ONE},     1'b1, '{ZERO, ZERO, 10'd1}},
        '{'{CMD_WRITE, 10'd512,  32'sd1, -32'sd1},    1'b1, '{ZERO, ZERO, 10'd512}},
        '{'{CMD_READ,  10'd1,    ZERO, ZERO},         1'b1, '{ONE, MINUS_ONE, 10'd1}},
        '{'{CMD_READ,  10'd512,  ZERO, ZERO},         1'b1, '{32'sd1, -32'sd1, 10'd512}},
        '{'{CMD_WRITE, 10'd2,    32'sh1234_5678, 32'shEDCB_A988}, 1'b0, '0},
        '{'{CMD_READ,  10'd2,    ZERO, ZERO},         1'b0, '0},
        '{'{CMD_APPLY, 10'd0,    ZERO, ZERO},         1'b1, '{ZERO, ZERO, 10'd0}},
        '{'{CMD_READ,  10'd1023, ZERO, ZERO},         1'b1, '{AMP_MIN, AMP_MAX, 10'd1023}},
        '{'{CMD_SPARE, 10'd0,    AMP_MIN, AMP_MAX},   1'b1, '{ZERO, ZERO, 10'd0}},
        '{'{CMD_WRITE, 10'd0,    ZERO, ZERO},         1'b1, '{ZERO, ZERO, 10'd0}},
        '{'{CMD_READ,  10'd0,    ZERO, ZERO},         1'b1, '{ZERO, ZERO, 10'd0}}
    };

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    in_item_t                s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    out_item_t               m_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0]       cfg_data  = '0;

    cplx_t                   state_vec [0:VEC_LEN-1];
    logic [TARGET_W-1:0]     gate_target = '0;
    gate_t                   gate_u      = {U_ONE, U_ZERO, U_ZERO, U_ONE};
    out_item_t               due_results [$];

    bit     calm        = 1'b0;
    bit     hold_ask    = 1'b0;
    bit     hold_served = 1'b0;
    int     n_sent      = 0;
    int     n_applies   = 0;
    int     n_checked   = 0;
    int     n_bad       = 0;
    longint cycles      = 0;

    single_qubit_gate_apply_top #(
        .QUBITS (QUBITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint qmul(logic signed [AMP_W-1:0] a, logic signed [AMP_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd536870912;
        return p >>> 30;
    endfunction

    function automatic logic signed [AMP_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647) return AMP_MAX;
        if (v < -64'sd2147483648) return AMP_MIN;
        return v[AMP_W-1:0];
    endfunction

    // x*c0 + y*c1 with rounded products and saturated parts
    function automatic cplx_t mac2(cplx_t x, cplx_t c0, cplx_t y, cplx_t c1);
        cplx_t  r;
        longint sre;
        longint sim;
        sre = qmul(x.re, c0.re) - qmul(x.im, c0.im) + qmul(y.re, c1.re) - qmul(y.im, c1.im);
        sim = qmul(x.re, c0.im) + qmul(x.im, c0.re) + qmul(y.re, c1.im) + qmul(y.im, c1.re);
        r.re = clamp32(sre);
        r.im = clamp32(sim);
        return r;
    endfunction

    function automatic out_item_t execute_command(in_item_t it);
        out_item_t   r;
        int unsigned slot;
        int unsigned lo;
        int unsigned hi;
        int          i;
        cplx_t       c0;
        cplx_t       c1;
        r = '0;
        r.out_index = it.amp_index;
        slot = it.amp_index & (VEC_LEN - 1);
        case (it.command)
            CMD_WRITE: begin
                state_vec[slot] = {it.amp_re, it.amp_im};
            end
            CMD_READ: begin
                r.out_re = state_vec[slot].re;
                r.out_im = state_vec[slot].im;
            end
            CMD_APPLY: begin
                if (gate_target < QUBITS) begin
                    for (i = 0; i < VEC_LEN / 2; i++) begin
                        lo = ((i >> gate_target) << (gate_target + 1))
                           | (i & ((1 << gate_target) - 1));
                        hi = lo | (1 << gate_target);
                        c0 = state_vec[lo];
                        c1 = state_vec[hi];
                        state_vec[lo] = mac2(gate_u.u00, c0, gate_u.u01, c1);
                        state_vec[hi] = mac2(gate_u.u10, c0, gate_u.u11, c1);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic signed [AMP_W-1:0] pick_amp();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return $signed($urandom) >>> 2;
        if (r < 85) return $urandom;
        case ($urandom_range(4))
            0: return AMP_MAX;
            1: return AMP_MIN;
            2: return ONE;
            3: return MINUS_ONE;
            default: return ZERO;
        endcase
    endfunction

    task automatic send_item(in_item_t it, logic typed = 1'b0, out_item_t want = '0);
        out_item_t r;
        if (!calm && $urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = execute_command(it);
        due_results.push_back(typed ? want : r);
        n_sent++;
        if (it.command == CMD_APPLY) n_applies++;
    endtask

    task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_TARGET: gate_target = d[TARGET_W-1:0];
            CFG_U00:    gate_u.u00 = d;
            CFG_U01:    gate_u.u01 = d;
            CFG_U10:    gate_u.u10 = d;
            CFG_U11:    gate_u.u11 = d;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing outstanding, out_index %0d", m_data.out_index);
                n_bad++;
            end else begin
                want = due_results.pop_front();
                n_checked++;
                if (m_data.out_re !== want.out_re) begin
                    $error("out_re: expected %0d, got %0d", want.out_re, m_data.out_re);
                    n_bad++;
                end
                if (m_data.out_im !== want.out_im) begin
                    $error("out_im: expected %0d, got %0d", want.out_im, m_data.out_im);
                    n_bad++;
                end
                if (m_data.out_index !== want.out_index) begin
                    $error("out_index: expected %0d, got %0d", want.out_index, m_data.out_index);
                    n_bad++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_single_qubit_gate_apply_top NOT OK");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold to fill the block up
    initial begin : sink
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_ask && !hold_served) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_served = 1'b1;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        in_item_t       it;
        gate_t          g;
        gate_kind_e     kind;
        logic [TARGET_W-1:0] tq;
        int             ph;
        int             n;
        int             j;
        int unsigned    r;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // target beyond the vector, and writes to unused register indexes
        put_reg(CFG_TARGET, {{(WORD_W-TARGET_W){1'b0}}, {TARGET_W{1'b1}}});
        for (j = CFG_SPARE; j < (1 << CFG_INDEX_W); j++) begin
            put_reg(CFG_INDEX_W'(j), {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;

        foreach (PROBES[j]) begin
            send_item(PROBES[j].item, PROBES[j].typed, PROBES[j].want);
        end
        drain();
        put_reg(CFG_TARGET, '0);
        cfg_valid <= 1'b0;

        // fill the whole vector so that any read or sweep sees written data
        hold_ask = 1'b1;
        for (j = 0; j < VEC_LEN; j++) begin
            it.command   = CMD_WRITE;
            it.amp_index = INDEX_W'(j);
            it.amp_re    = pick_amp();
            it.amp_im    = pick_amp();
            send_item(it);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                calm = (ph == PHASES - 1);
                if (ph == 1) tq = TARGET_W'(QUBITS - 1);
                else if (ph == 2) tq = '0;
                else if (ph == 3) tq = TARGET_W'($urandom_range((1 << TARGET_W) - 1, QUBITS));
                else tq = TARGET_W'($urandom_range(QUBITS - 1));
                if (ph == 4) kind = G_FLOOR;
                else if (ph == 5) kind = G_CEIL;
                else if (ph == 6) kind = G_NOISE;
                else kind = gate_kind_e'($urandom_range(G_SMALL));
                case (kind)
                    G_HADAMARD: g = {INV_SQRT2, ZERO, INV_SQRT2, ZERO,
                                     INV_SQRT2, ZERO, -INV_SQRT2, ZERO};
                    G_PAULI_X:  g = {ZERO, ZERO, ONE, ZERO, ONE, ZERO, ZERO, ZERO};
                    G_PAULI_Y:  g = {ZERO, ZERO, ZERO, MINUS_ONE, ZERO, ONE, ZERO, ZERO};
                    G_PAULI_Z:  g = {ONE, ZERO, ZERO, ZERO, ZERO, ZERO, MINUS_ONE, ZERO};
                    G_FLOOR:    g = {8{AMP_MIN}};
                    G_CEIL:     g = {8{AMP_MAX}};
                    G_NOISE:    g = {$urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom};
                    default: begin
                        for (j = 0; j < 8; j++) g[j*AMP_W +: AMP_W] = $signed($urandom) >>> 3;
                    end
                endcase
                put_reg(CFG_TARGET, {{(WORD_W-TARGET_W){1'b0}}, tq});
                put_reg(CFG_U00, g.u00);
                put_reg(CFG_U01, g.u01);
                put_reg(CFG_U10, g.u10);
                put_reg(CFG_U11, g.u11);
                cfg_valid <= 1'b0;
            end
            for (n = 0; n < PER_PHASE; n++) begin
                r = $urandom_range(99);
                it.command   = (r < 38) ? CMD_WRITE : (r < 80) ? CMD_READ :
                               (r < 93) ? CMD_APPLY : CMD_SPARE;
                it.amp_index = INDEX_W'($urandom_range(VEC_LEN - 1));
                it.amp_re    = pick_amp();
                it.amp_im    = pick_amp();
                send_item(it);
            end
        end

        drain();
        repeat (16) @(posedge aclk);
        $display("%0d commands sent, %0d of them gate sweeps, over %0d gate settings",
                 n_sent, n_applies, PHASES + 1);
        $display("%0d result beats checked, %0d field mismatches", n_checked, n_bad);
        if (n_bad == 0) begin
            $display("tb_single_qubit_gate_apply_top OK");
        end else begin
            $display("tb_single_qubit_gate_apply_top NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/sqga_pkg.sv
sv/sqga_ram.sv
sv/sqga_butterfly.sv
sv/single_qubit_gate_apply_top.sv
verif/tb_single_qubit_gate_apply_top.sv
